### hdl/bbpt_pkg.sv
// ----------------------------------------------------------------------------
// Bang-bang position tracker package
// Shared widths, register indexes, reset values and the types that travel
// along the square-root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bbpt_pkg;

  localparam int DATA_W    = 32;  // Q16.16 position and velocity
  localparam int CFG_W     = 24;  // unsigned limit registers
  localparam int ACC_W     = 25;  // signed acceleration command
  localparam int RAD_W     = 56;  // radicand 2*|e|*max_accel
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int CFG_IDX_W = 2;
  localparam int DBAND_W   = 17;  // floor(max_accel / 200)
  localparam int VBAND_W   = 20;  // floor(max_accel / 20)

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 2'd1;

  localparam logic [CFG_W-1:0] MAX_SPEED_RST = 24'd65536;
  localparam logic [CFG_W-1:0] MAX_ACCEL_RST = 24'd65536;

  // Reciprocals for the band dividers, scaled by 2^RECIP_SHIFT and rounded
  // down. The quotient they give is low by at most one.
  localparam int              RECIP_SHIFT = 24;
  localparam logic [19:0]     RECIP_25    = 20'd671088;
  localparam logic [21:0]     RECIP_5     = 22'd3355443;

  // Working value of one square-root step.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, top first
    logic [REM_W-1:0]  rem;   // partial remainder
    logic [ROOT_W-1:0] root;  // root bits found so far
  } sqrt_work_t;

  // Item data that rides alongside the square root.
  typedef struct packed {
    logic signed [DATA_W-1:0] err;  // saturated position error
    logic signed [DATA_W-1:0] vel;  // measured velocity
  } sqrt_tag_t;

endpackage

`default_nettype wire

### hdl/bbpt_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square-root cell
// One restoring step of the integer square root: takes the next two
// radicand bits, decides one root bit and passes the result on.
// ----------------------------------------------------------------------------
`default_nettype none

module bbpt_sqrt_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    ce,
  input  wire                    in_valid,
  input  bbpt_pkg::sqrt_work_t   in_work,
  input  bbpt_pkg::sqrt_tag_t    in_tag,
  output logic                   out_valid,
  output bbpt_pkg::sqrt_work_t   out_work,
  output bbpt_pkg::sqrt_tag_t    out_tag
);

  logic [bbpt_pkg::REM_W-1:0] rem_sh;
  logic [bbpt_pkg::REM_W-1:0] trial;
  logic                       take;
  bbpt_pkg::sqrt_work_t       work_next;

  // The remainder never exceeds twice the root, so the top bits dropped by
  // the shift are always zero.
  always_comb begin
    rem_sh = {in_work.rem[bbpt_pkg::REM_W-3:0],
              in_work.rad[bbpt_pkg::RAD_W-1 -: 2]};
    trial  = {in_work.root, 2'b01};
    take   = (rem_sh >= trial);
    work_next.rad  = {in_work.rad[bbpt_pkg::RAD_W-3:0], 2'b00};
    work_next.rem  = take ? (rem_sh - trial) : rem_sh;
    work_next.root = {in_work.root[bbpt_pkg::ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_work <= work_next;
      out_tag  <= in_tag;
    end
  end

endmodule

`default_nettype wire

### hdl/bbpt_band_calc.sv
// ----------------------------------------------------------------------------
// Hysteresis band calculator
// Derives the position band max_accel/200 and the velocity band
// max_accel/20 by reciprocal multiplication with a one-step correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bbpt_band_calc (
  input  wire                                 clk,
  input  wire  [bbpt_pkg::CFG_W-1:0]          max_accel,
  output logic [bbpt_pkg::DBAND_W-1:0]        d_band,
  output logic [bbpt_pkg::VBAND_W-1:0]        v_band
);

  // a/200 = (a/8)/25 and a/20 = (a/4)/5, both with floors.
  logic [20:0]                   x_d;
  logic [21:0]                   x_v;
  logic [40:0]                   prod_d;
  logic [43:0]                   prod_v;
  logic [20:0]                   x_d_q;
  logic [21:0]                   x_v_q;
  logic [bbpt_pkg::DBAND_W-1:0]  q_d;
  logic [bbpt_pkg::VBAND_W-1:0]  q_v;
  logic [21:0]                   r_d;
  logic [22:0]                   r_v;

  always_comb begin
    x_d    = max_accel[bbpt_pkg::CFG_W-1:3];
    x_v    = max_accel[bbpt_pkg::CFG_W-1:2];
    prod_d = 41'(x_d) * 41'(bbpt_pkg::RECIP_25);
    prod_v = 44'(x_v) * 44'(bbpt_pkg::RECIP_5);
    r_d    = 22'(x_d_q) - 22'(22'(q_d) * 22'd25);
    r_v    = 23'(x_v_q) - 23'(23'(q_v) * 23'd5);
  end

  always_ff @(posedge clk) begin
    x_d_q  <= x_d;
    x_v_q  <= x_v;
    q_d    <= prod_d[bbpt_pkg::RECIP_SHIFT +: bbpt_pkg::DBAND_W];
    q_v    <= prod_v[bbpt_pkg::RECIP_SHIFT +: bbpt_pkg::VBAND_W];
    d_band <= (r_d >= 22'd25) ? (q_d + 1'b1) : q_d;
    v_band <= (r_v >= 23'd5) ? (q_v + 1'b1) : q_v;
  end

endmodule

`default_nettype wire

### hdl/bang_bang_position_tracker_core.sv
// ----------------------------------------------------------------------------
// Bang-bang position tracker core
// Time-optimal one-axis controller: braking-curve speed from the position
// error, then a +/-max_accel or zero command from the velocity error.
// ----------------------------------------------------------------------------
// Pipeline depth: 32 register stages. Throughput: one request per cycle unless the
// pipeline holds, as described below; the square
// root is a chain of 28 cells, one root bit per cell, and every stage is registered.
// The pipeline holds only while a result waits on m_tready and the stage
// behind the output register is also full.
// Reset clears all valid flags and loads max_speed and max_accel with 1.0.
`default_nettype none

module bang_bang_position_tracker_core (
  input  wire                                clk,
  input  wire                                rst,
  // Input requests.
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [95:0]                        s_tdata,  // target_pos, current_pos, current_vel
  // Results.
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [31:0]                        m_tdata,  // accel_cmd, zero fill
  // Configuration writes.
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [bbpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [bbpt_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DW = bbpt_pkg::DATA_W;
  localparam int RW = bbpt_pkg::ROOT_W;

  logic [bbpt_pkg::CFG_W-1:0]   max_speed;
  logic [bbpt_pkg::CFG_W-1:0]   max_accel;
  logic [bbpt_pkg::DBAND_W-1:0] d_band;
  logic [bbpt_pkg::VBAND_W-1:0] v_band;
  logic                         ce;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= bbpt_pkg::MAX_SPEED_RST;
      max_accel <= bbpt_pkg::MAX_ACCEL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bbpt_pkg::REG_MAX_SPEED: max_speed <= cfg_data;
        bbpt_pkg::REG_MAX_ACCEL: max_accel <= cfg_data;
        default: ;
      endcase
    end
  end

  bbpt_band_calc u_band (
    .clk       (clk),
    .max_accel (max_accel),
    .d_band    (d_band),
    .v_band    (v_band)
  );

  // Stage 1: saturated position error and its magnitude.
  logic signed [DW:0]   e_full;
  logic signed [DW-1:0] e_sat;
  logic                 s1_valid;
  logic signed [DW-1:0] s1_err;
  logic signed [DW-1:0] s1_vel;
  logic [DW-1:0]        s1_abs;

  always_comb begin
    e_full = $signed({s_tdata[31], s_tdata[31:0]}) - $signed({s_tdata[63], s_tdata[63:32]});
    if (e_full[DW] != e_full[DW-1]) begin
      e_sat = e_full[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      e_sat = e_full[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ce) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_err <= e_sat;
      s1_vel <= s_tdata[95:64];
      s1_abs <= e_sat[DW-1] ? (~e_sat + 1'b1) : e_sat;
    end
  end

  // Stage 2: radicand 2*|e|*max_accel. The product stays below 2^55.
  logic [DW+bbpt_pkg::CFG_W-1:0] prod;
  logic                          s2_valid;
  bbpt_pkg::sqrt_work_t          s2_work;
  bbpt_pkg::sqrt_tag_t           s2_tag;

  assign prod = (DW + bbpt_pkg::CFG_W)'(s1_abs) * (DW + bbpt_pkg::CFG_W)'(max_accel);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ce) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_work.rad  <= {prod[bbpt_pkg::RAD_W-2:0], 1'b0};
      s2_work.rem  <= '0;
      s2_work.root <= '0;
      s2_tag.err   <= s1_err;
      s2_tag.vel   <= s1_vel;
    end
  end

  // Square-root cell chain.
  logic                 cell_valid [0:RW];
  bbpt_pkg::sqrt_work_t cell_work  [0:RW];
  bbpt_pkg::sqrt_tag_t  cell_tag   [0:RW];

  assign cell_valid[0] = s2_valid;
  assign cell_work[0]  = s2_work;
  assign cell_tag[0]   = s2_tag;

  for (genvar i = 0; i < RW; i++) begin : g_cell
    bbpt_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (cell_valid[i]),
      .in_work   (cell_work[i]),
      .in_tag    (cell_tag[i]),
      .out_valid (cell_valid[i+1]),
      .out_work  (cell_work[i+1]),
      .out_tag   (cell_tag[i+1])
    );
  end

  // Target speed stage: clamp, band test and sign toward the target.
  logic [RW-1:0]                 root;
  logic [bbpt_pkg::CFG_W-1:0]    spd;
  logic signed [DW-1:0]          pos_dband;
  logic signed [DW-1:0]          neg_dband;
  logic signed [bbpt_pkg::ACC_W-1:0] spd_s;
  logic signed [bbpt_pkg::ACC_W-1:0] v_tgt_next;
  logic                          vt_valid;
  logic signed [bbpt_pkg::ACC_W-1:0] vt_tgt;
  logic signed [DW-1:0]          vt_vel;

  always_comb begin
    root      = cell_work[RW].root;
    spd       = (root > RW'(max_speed)) ? max_speed : root[bbpt_pkg::CFG_W-1:0];
    spd_s     = $signed({1'b0, spd});
    pos_dband = $signed(DW'(d_band));
    neg_dband = -pos_dband;
    if (cell_tag[RW].err > pos_dband) begin
      v_tgt_next = spd_s;
    end else if (cell_tag[RW].err < neg_dband) begin
      v_tgt_next = -spd_s;
    end else begin
      v_tgt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vt_valid <= 1'b0;
    end else if (ce) begin
      vt_valid <= cell_valid[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      vt_tgt <= v_tgt_next;
      vt_vel <= cell_tag[RW].vel;
    end
  end

  // Output stage: velocity error against the velocity band.
  logic signed [DW+1:0]              v_err;
  logic signed [DW+1:0]              pos_vband;
  logic signed [DW+1:0]              neg_vband;
  logic signed [bbpt_pkg::ACC_W-1:0] acc_pos;
  logic signed [bbpt_pkg::ACC_W-1:0] acc_next;
  logic signed [bbpt_pkg::ACC_W-1:0] accel_cmd;
  logic                              out_valid;

  always_comb begin
    v_err     = $signed({{(DW+2-bbpt_pkg::ACC_W){vt_tgt[bbpt_pkg::ACC_W-1]}}, vt_tgt})
              - $signed({{2{vt_vel[DW-1]}}, vt_vel});
    pos_vband = $signed((DW+2)'(v_band));
    neg_vband = -pos_vband;
    acc_pos   = $signed({1'b0, max_accel});
    if (v_err > pos_vband) begin
      acc_next = acc_pos;
    end else if (v_err < neg_vband) begin
      acc_next = -acc_pos;
    end else begin
      acc_next = '0;
    end
  end

  // The pipeline moves unless a result is stuck and the last stage is full.
  assign ce       = !(out_valid && !m_tready && vt_valid);
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vt_valid || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (ce && vt_valid) begin
      accel_cmd <= acc_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(32-bbpt_pkg::ACC_W){1'b0}}, accel_cmd};

  // Assertions.
  a_cmd_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (accel_cmd == '0) || (accel_cmd == acc_pos) || (accel_cmd == -acc_pos))
    else $error("accel_cmd is not zero or +/-max_accel");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> out_valid && !m_tready && vt_valid)
    else $error("input held off without a stalled result");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vt_valid))
    else $error("result appeared without an item in the last stage");

  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (vt_valid && !ce) |=> vt_valid && out_valid)
    else $error("item lost during a stall");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bang-bang position tracker core testbench
// Drives target/current position and velocity requests, predicts the
// commanded acceleration for each accepted request, and checks every result
// in order. Limits are changed between phases and both stream sides idle at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int RND_PER_PHASE = 78;
  localparam int N_PHASES      = 8;

  // Packed so that target_pos lands in the lowest bits of s_tdata.
  typedef struct packed {
    logic signed [bbpt_pkg::DATA_W-1:0] current_vel;
    logic signed [bbpt_pkg::DATA_W-1:0] current_pos;
    logic signed [bbpt_pkg::DATA_W-1:0] target_pos;
  } track_req_t;

  class accel_scoreboard;
    logic [bbpt_pkg::CFG_W-1:0] speed_lim;
    logic [bbpt_pkg::CFG_W-1:0] accel_lim;
    logic [bbpt_pkg::ACC_W-1:0] cmd_q[$];
    int n_req, n_cmd, n_fail, n_plus, n_minus, n_zero;

    function new();
      speed_lim = bbpt_pkg::MAX_SPEED_RST;
      accel_lim = bbpt_pkg::MAX_ACCEL_RST;
      n_req = 0; n_cmd = 0; n_fail = 0;
      n_plus = 0; n_minus = 0; n_zero = 0;
    endfunction

    function void write_limit(logic [bbpt_pkg::CFG_IDX_W-1:0] idx,
                              logic [bbpt_pkg::CFG_W-1:0] val);
      case (idx)
        bbpt_pkg::REG_MAX_SPEED: speed_lim = val;
        bbpt_pkg::REG_MAX_ACCEL: accel_lim = val;
        default: ;
      endcase
    endfunction

    // Position error, saturated to the signed 32-bit range.
    function longint pos_error(logic signed [bbpt_pkg::DATA_W-1:0] tgt,
                               logic signed [bbpt_pkg::DATA_W-1:0] cur);
      longint e;
      e = longint'(tgt) - longint'(cur);
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      if (e < -64'sd2147483648) e = -64'sd2147483648;
      return e;
    endfunction

    // Largest r with r*r <= rad, one bit at a time from the top.
    function longint braking_root(longint rad);
      longint r;
      longint t;
      r = 0;
      for (int b = bbpt_pkg::ROOT_W - 1; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= rad) r = t;
      end
      return r;
    endfunction

    // Signed speed toward the target, zero inside the position band.
    function longint target_speed(longint e);
      longint a, ab, spd, dband;
      a = longint'(accel_lim);
      dband = a * 5 / 1000;
      ab = (e < 0) ? -e : e;
      spd = braking_root(2 * ab * a);
      if (spd > longint'(speed_lim)) spd = longint'(speed_lim);
      if (e > dband) return spd;
      if (e < -dband) return -spd;
      return 0;
    endfunction

    function logic [bbpt_pkg::ACC_W-1:0] accel_for(track_req_t r);
      longint a, vband, verr, acc;
      a = longint'(accel_lim);
      vband = a * 50 / 1000;
      verr = target_speed(pos_error(r.target_pos, r.current_pos)) - longint'(r.current_vel);
      if (verr > vband) acc = a;
      else if (verr < -vband) acc = -a;
      else acc = 0;
      return acc[bbpt_pkg::ACC_W-1:0];
    endfunction

    function void note_request(track_req_t r);
      cmd_q.push_back(accel_for(r));
      n_req++;
    endfunction

    function void check_command(logic [31:0] d);
      logic [bbpt_pkg::ACC_W-1:0] want;
      logic [bbpt_pkg::ACC_W-1:0] got;
      got = d[bbpt_pkg::ACC_W-1:0];
      n_cmd++;
      if (cmd_q.size() == 0) begin
        $error("accel_cmd: result with no request outstanding, got %0d", $signed(got));
        n_fail++;
        return;
      end
      want = cmd_q.pop_front();
      if (got !== want) begin
        $error("accel_cmd: expected %0d, actual %0d", $signed(want), $signed(got));
        n_fail++;
      end
      if ($signed(got) > 0) n_plus++;
      else if ($signed(got) < 0) n_minus++;
      else n_zero++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [95:0] s_tdata = '0;  // target_pos, current_pos, current_vel
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;       // accel_cmd, zero fill
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bbpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbpt_pkg::CFG_W-1:0] cfg_data = '0;

  accel_scoreboard sb = new();

  bang_bang_position_tracker_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("bang_bang_position_tracker_core verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(s_tdata);
      if (m_tvalid && m_tready) sb.check_command(m_tdata);
    end
  end

  // Result side: random stall patterns, plus one long hold-off once enough
  // requests have gone in, so the pipeline fills and backs up to s_tready.
  int  rx_mode = 0;
  int  rx_left = 0;
  int  rx_step = 0;
  int  rx_seen = 0;
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) rx_seen <= rx_seen + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (!long_hold_done && rx_seen >= 250) begin
        long_hold_done <= 1'b1;
        hold_left <= 400;
        m_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode <= $urandom_range(0, 3);
          rx_left <= $urandom_range(10, 150);
        end else begin
          rx_left <= rx_left - 1;
        end
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_step % 3 != 2);
        endcase
        rx_step <= rx_step + 1;
      end
    end
  end

  int burst_left = 0;

  task automatic offer(track_req_t r);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= r;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7: gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 40);
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The caller drops cfg_valid once its last write has gone in.
  task automatic write_limit(logic [bbpt_pkg::CFG_IDX_W-1:0] idx,
                             logic [bbpt_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_limit(idx, val);
  endtask

  // Stop sending and wait until every predicted command has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.cmd_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic track_req_t req(logic [31:0] tgt, logic [31:0] cur, logic [31:0] vel);
    track_req_t r;
    r.target_pos = tgt;
    r.current_pos = cur;
    r.current_vel = vel;
    return r;
  endfunction

  // Errors near the band edges, up to 2^20 or full range, with velocities near the
  // target speed, so all three commands and both band edges get hit; some raw noise too.
  function automatic track_req_t random_req();
    track_req_t r;
    longint a, db, vb, delta, vel;
    int pick;
    a = longint'(sb.accel_lim);
    db = a * 5 / 1000;
    vb = a * 50 / 1000;
    r.target_pos = $urandom;
    r.current_pos = $urandom;
    r.current_vel = $urandom;
    pick = $urandom_range(0, 9);
    if (pick == 0) return r;
    if (pick == 1) begin
      r.target_pos[31:30] = 2'b01;
      r.current_pos[31:30] = 2'b10;
      if ($urandom_range(0, 1)) begin
        r.target_pos = r.current_pos;
        r.current_pos[31:30] = 2'b01;
        r.target_pos[31:30] = 2'b10;
      end
    end else begin
      case ($urandom_range(0, 2))
        0: delta = longint'($urandom_range(0, 2 * db + 3));
        1: delta = longint'($urandom_range(0, 1 << 20));
        default: delta = longint'($urandom_range(0, 32'h7fffffff));
      endcase
      if ($urandom_range(0, 1)) delta = -delta;
      r.target_pos = r.current_pos + delta[31:0];
    end
    vel = sb.target_speed(sb.pos_error(r.target_pos, r.current_pos))
          + longint'($urandom_range(0, 2 * vb + 6)) - (vb + 3);
    r.current_vel = vel[31:0];
    return r;
  endfunction

  // A few corners worth repeating under each phase's new limit setting.
  task automatic corner_reqs();
    offer(req(32'd0, 32'd0, 32'd0));
    offer(req(32'h7fffffff, 32'h80000000, 32'd0));
    offer(req(32'h80000000, 32'h7fffffff, 32'h7fffffff));
    offer(req(32'd1, 32'd0, 32'h80000000));
  endtask

  initial begin
    logic [bbpt_pkg::CFG_W-1:0] spd_set;
    logic [bbpt_pkg::CFG_W-1:0] acc_set;
    logic [31:0] rnd;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limits of 1.0: position band 327, velocity band 3276.
    offer(req(32'd0, 32'd0, 32'd0));
    offer(req(32'd0, 32'd0, -32'sd3276));
    offer(req(32'd0, 32'd0, -32'sd3277));
    offer(req(32'd0, 32'd0, 32'sd3277));
    offer(req(32'd327, 32'd0, 32'd0));
    offer(req(-32'sd327, 32'd0, 32'd0));
    offer(req(32'd328, 32'd0, 32'd0));
    offer(req(-32'sd328, 32'd0, 32'd0));
    offer(req(32'h7fffffff, 32'h80000000, 32'd65536));
    offer(req(32'h80000000, 32'h7fffffff, -32'sd65536));
    offer(req(32'h7fffffff, 32'h80000000, 32'h7fffffff));
    offer(req(32'h80000000, 32'h7fffffff, 32'h80000000));
    offer(req(32'h40000000, 32'd0, 32'd62260));
    offer(req(32'h40000000, 32'd0, 32'd62259));
    offer(req(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
    offer(req(32'h55555555, 32'haaaaaaaa, 32'h55555555));
    offer(req(32'hffffffff, 32'hffffffff, 32'hffffffff));
    repeat (RND_PER_PHASE) offer(random_req());
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin spd_set = 24'hffffff; acc_set = 24'hffffff; end
        1: begin spd_set = 24'd0;      acc_set = 24'd65536;  end
        2: begin spd_set = 24'd65536;  acc_set = 24'd0;      end
        3: begin spd_set = 24'd0;      acc_set = 24'd0;      end
        4: begin spd_set = 24'd1;      acc_set = 24'd1;      end
        5: begin
          rnd = $urandom;
          spd_set = rnd[bbpt_pkg::CFG_W-1:0];
          rnd = $urandom_range(199, 4000);
          acc_set = rnd[bbpt_pkg::CFG_W-1:0];
        end
        6: begin
          rnd = $urandom;
          spd_set = rnd[bbpt_pkg::CFG_W-1:0];
          rnd = $urandom;
          acc_set = rnd[bbpt_pkg::CFG_W-1:0];
        end
        default: begin spd_set = 24'd262144; acc_set = 24'd131072; end
      endcase
      write_limit(bbpt_pkg::REG_MAX_SPEED, spd_set);
      write_limit(bbpt_pkg::REG_MAX_ACCEL, acc_set);
      cfg_valid <= 1'b0;
      corner_reqs();
      repeat (RND_PER_PHASE) offer(random_req());
      drain();
    end

    $display("Checked %0d commands from %0d requests over %0d limit settings.",
             sb.n_cmd, sb.n_req, N_PHASES + 1);
    $display("Commands seen: %0d accelerate, %0d brake, %0d coast.",
             sb.n_plus, sb.n_minus, sb.n_zero);
    if (sb.n_fail == 0) begin
      $display("bang_bang_position_tracker_core verification clean");
    end else begin
      $display("bang_bang_position_tracker_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hdl/bbpt_pkg.sv
hdl/bbpt_sqrt_cell.sv
hdl/bbpt_band_calc.sv
hdl/bang_bang_position_tracker_core.sv
verif/tb_top.sv
